// ===== rtl/bresenham_line_stepper_defines.svh =====
// assertion macros used by the line stepper core rtl
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// same-cycle implication
`define BLS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bls_pkg.sv =====
package bls_pkg;

   localparam int COORD_BITS    = 12;
   localparam int COLOR_BITS    = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int X_LIMIT_RESET = 239;
   localparam int Y_LIMIT_RESET = 399;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } bls_opcode_type;

   // register index, taken from address bit 2
   typedef enum logic {
      REG_X_LIMIT = 1'b0,
      REG_Y_LIMIT = 1'b1
   } bls_reg_type;

endpackage

// ===== rtl/bls_csr.sv =====
module bls_csr #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bls_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bls_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bls_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [COORD_BITS-1:0]              x_limit,
   output logic [COORD_BITS-1:0]              y_limit
);

   logic [COORD_BITS-1:0] x_limit_ff, x_limit_in;
   logic [COORD_BITS-1:0] y_limit_ff, y_limit_in;
   logic                  wr_en;
   bls_pkg::bls_reg_type  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = bls_pkg::bls_reg_type'(csr_paddr[2]);

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      csr_prdata = '0;
      unique case (reg_sel)
         bls_pkg::REG_X_LIMIT: begin
            csr_prdata = bls_pkg::CSR_DATA_BITS'(x_limit_ff);
            if (wr_en) x_limit_in = csr_pwdata[COORD_BITS-1:0];
         end
         bls_pkg::REG_Y_LIMIT: begin
            csr_prdata = bls_pkg::CSR_DATA_BITS'(y_limit_ff);
            if (wr_en) y_limit_in = csr_pwdata[COORD_BITS-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= COORD_BITS'(bls_pkg::X_LIMIT_RESET);
         y_limit_ff <= COORD_BITS'(bls_pkg::Y_LIMIT_RESET);
      end else begin
         x_limit_ff <= x_limit_in;
         y_limit_ff <= y_limit_in;
      end
   end

   assign x_limit = x_limit_ff;
   assign y_limit = y_limit_ff;

endmodule

// ===== rtl/bls_req_reg.sv =====
module bls_req_reg #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [COORD_BITS-1:0]             req_x_start,
   input  logic [COORD_BITS-1:0]             req_y_start,
   input  logic [COORD_BITS-1:0]             req_x_end,
   input  logic [COORD_BITS-1:0]             req_y_end,
   input  logic [bls_pkg::COLOR_BITS-1:0]    req_color,
   input  logic                              advance,
   output logic                              in_valid,
   output bls_pkg::bls_opcode_type           in_opcode,
   output logic [COORD_BITS-1:0]             in_x_start,
   output logic [COORD_BITS-1:0]             in_y_start,
   output logic [COORD_BITS-1:0]             in_x_end,
   output logic [COORD_BITS-1:0]             in_y_end,
   output logic [bls_pkg::COLOR_BITS-1:0]    in_color
);

   logic                           valid_ff, valid_in;
   logic                           take;
   bls_pkg::bls_opcode_type        opcode_ff;
   logic [COORD_BITS-1:0]          x_start_ff, y_start_ff, x_end_ff, y_end_ff;
   logic [bls_pkg::COLOR_BITS-1:0] color_ff;

   // the register frees up in the same cycle the core consumes it
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b1;
      else if (advance) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         opcode_ff  <= bls_pkg::bls_opcode_type'(req_opcode);
         x_start_ff <= req_x_start;
         y_start_ff <= req_y_start;
         x_end_ff   <= req_x_end;
         y_end_ff   <= req_y_end;
         color_ff   <= req_color;
      end
   end

   assign in_valid   = valid_ff;
   assign in_opcode  = opcode_ff;
   assign in_x_start = x_start_ff;
   assign in_y_start = y_start_ff;
   assign in_x_end   = x_end_ff;
   assign in_y_end   = y_end_ff;
   assign in_color   = color_ff;

endmodule

// ===== rtl/bls_line_core.sv =====
`include "bresenham_line_stepper_defines.svh"

module bls_line_core #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  bls_pkg::bls_opcode_type           in_opcode,
   input  logic [COORD_BITS-1:0]             in_x_start,
   input  logic [COORD_BITS-1:0]             in_y_start,
   input  logic [COORD_BITS-1:0]             in_x_end,
   input  logic [COORD_BITS-1:0]             in_y_end,
   input  logic [bls_pkg::COLOR_BITS-1:0]    in_color,
   output logic                              advance,
   input  logic [COORD_BITS-1:0]             x_limit,
   input  logic [COORD_BITS-1:0]             y_limit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_valid_res,
   output logic [COORD_BITS-1:0]             rsp_pixel_x,
   output logic [COORD_BITS-1:0]             rsp_pixel_y,
   output logic [bls_pkg::COLOR_BITS-1:0]    rsp_pixel_color,
   output logic                              rsp_visible,
   output logic                              rsp_last
);

   localparam int ERR_BITS = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   // line state: holds the last emitted pixel and its error term
   coord_type                      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   err_type                        err_ff, err_in;
   coord_type                      dx_ff, dx_in, dy_ff, dy_in;
   logic                           sxn_ff, sxn_in, syn_ff, syn_in;
   logic                           xmaj_ff, xmaj_in;
   coord_type                      left_ff, left_in;
   logic [bls_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic                           busy_ff, busy_in;

   // result register
   logic                           out_valid_ff;
   logic                           o_valid_res_ff, o_valid_res_in;
   coord_type                      o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic [bls_pkg::COLOR_BITS-1:0] o_color_ff, o_color_in;
   logic                           o_vis_ff, o_vis_in;
   logic                           o_last_ff, o_last_in;

   // load path
   logic      gt_x, gt_y;
   coord_type ld_dx, ld_dy, ld_major;
   logic      ld_xmaj;

   // step path
   coord_type st_major, st_minor, st_x, st_y, left_dec;
   err_type   err_add, err_sub;
   logic      err_ge;

   assign advance = in_valid && (!out_valid_ff || !rsp_stall);

   always_comb begin
      gt_x     = in_x_end > in_x_start;
      gt_y     = in_y_end > in_y_start;
      ld_dx    = gt_x ? in_x_end - in_x_start : in_x_start - in_x_end;
      ld_dy    = gt_y ? in_y_end - in_y_start : in_y_start - in_y_end;
      ld_xmaj  = ld_dx > ld_dy;
      ld_major = ld_xmaj ? ld_dx : ld_dy;

      st_major = xmaj_ff ? dx_ff : dy_ff;
      st_minor = xmaj_ff ? dy_ff : dx_ff;
      err_add  = err_ff + $signed({2'b00, st_minor, 1'b0});
      err_ge   = !err_add[ERR_BITS-1];
      err_sub  = err_add - $signed({2'b00, st_major, 1'b0});
      left_dec = left_ff - COORD_BITS'(1);

      // major axis always moves, minor axis only when the error crosses zero
      st_x = cur_x_ff;
      st_y = cur_y_ff;
      if (xmaj_ff || err_ge) st_x = sxn_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
      if (!xmaj_ff || err_ge) st_y = syn_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
   end

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in   = err_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sxn_in   = sxn_ff;
      syn_in   = syn_ff;
      xmaj_in  = xmaj_ff;
      left_in  = left_ff;
      color_in = color_ff;
      busy_in  = busy_ff;

      o_valid_res_in = 1'b0;
      o_x_in         = '0;
      o_y_in         = '0;
      o_color_in     = '0;
      o_last_in      = 1'b0;

      if (advance) begin
         if (in_opcode == bls_pkg::OP_LOAD) begin
            cur_x_in = in_x_start;
            cur_y_in = in_y_start;
            err_in   = -$signed({3'b000, ld_major});
            dx_in    = ld_dx;
            dy_in    = ld_dy;
            sxn_in   = !gt_x;
            syn_in   = !gt_y;
            xmaj_in  = ld_xmaj;
            left_in  = ld_major;
            color_in = in_color;
            busy_in  = ld_major != '0;

            o_valid_res_in = 1'b1;
            o_x_in         = in_x_start;
            o_y_in         = in_y_start;
            o_color_in     = in_color;
            o_last_in      = ld_major == '0;
         end else if (busy_ff) begin
            cur_x_in = st_x;
            cur_y_in = st_y;
            err_in   = err_ge ? err_sub : err_add;
            left_in  = left_dec;
            busy_in  = left_dec != '0;

            o_valid_res_in = 1'b1;
            o_x_in         = st_x;
            o_y_in         = st_y;
            o_color_in     = color_ff;
            o_last_in      = left_dec == '0;
         end
      end

      o_vis_in = o_valid_res_in && (o_x_in <= x_limit) && (o_y_in <= y_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (advance) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff   <= err_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sxn_ff   <= sxn_in;
      syn_ff   <= syn_in;
      xmaj_ff  <= xmaj_in;
      left_ff  <= left_in;
      color_ff <= color_in;
      if (advance) begin
         o_valid_res_ff <= o_valid_res_in;
         o_x_ff         <= o_x_in;
         o_y_ff         <= o_y_in;
         o_color_ff     <= o_color_in;
         o_vis_ff       <= o_vis_in;
         o_last_ff      <= o_last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_valid_res   = o_valid_res_ff;
   assign rsp_pixel_x     = o_x_ff;
   assign rsp_pixel_y     = o_y_ff;
   assign rsp_pixel_color = o_color_ff;
   assign rsp_visible     = o_vis_ff;
   assign rsp_last        = o_last_ff;

   `BLS_ASSERT_NEXT(a_idle_step_empty, clock, reset, advance && in_opcode == bls_pkg::OP_STEP && !busy_ff, !o_valid_res_ff && !o_last_ff && !o_vis_ff, "step while idle produced a pixel")
   `BLS_ASSERT_NEXT(a_load_busy_last, clock, reset, advance && in_opcode == bls_pkg::OP_LOAD, o_valid_res_ff && (busy_ff == !o_last_ff), "load left busy and last flag inconsistent")
   `BLS_ASSERT_SAME(a_busy_has_pixels, clock, reset, busy_ff, left_ff != '0, "busy with no pixels left")
   `BLS_ASSERT_NEXT(a_last_ends_line, clock, reset, advance && o_last_in, !busy_ff, "line still busy after its last pixel")

endmodule

// ===== rtl/bresenham_line_stepper.sv =====
// Bresenham line stepper: a load transaction (opcode 0) takes two endpoints and a color and
// returns the first pixel of the line; each step transaction (opcode 1) returns the next pixel,
// with last set on the final one of max(dx,dy)+1 pixels. A step with no line in progress returns
// valid_res = 0 and all other fields zero, and a load abandons any line in progress. visible is
// set when the pixel lies at or below both limit registers (csr address 0: x_limit, address 4:
// y_limit, reset to 239 and 399). One transaction is taken every clock cycle while the result
// side is not stalled; a request waits in the input register until the error update and
// coordinate step load the result register, which then presents the result. A stalled result
// holds the input register, which stalls the request side.
module bresenham_line_stepper #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [COORD_BITS-1:0]             req_x_start,
   input  logic [COORD_BITS-1:0]             req_y_start,
   input  logic [COORD_BITS-1:0]             req_x_end,
   input  logic [COORD_BITS-1:0]             req_y_end,
   input  logic [bls_pkg::COLOR_BITS-1:0]    req_color,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_valid_res,
   output logic [COORD_BITS-1:0]             rsp_pixel_x,
   output logic [COORD_BITS-1:0]             rsp_pixel_y,
   output logic [bls_pkg::COLOR_BITS-1:0]    rsp_pixel_color,
   output logic                              rsp_visible,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bls_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [bls_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [bls_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   logic [COORD_BITS-1:0]          x_limit, y_limit;
   logic                           advance;
   logic                           in_valid;
   bls_pkg::bls_opcode_type        in_opcode;
   logic [COORD_BITS-1:0]          in_x_start, in_y_start, in_x_end, in_y_end;
   logic [bls_pkg::COLOR_BITS-1:0] in_color;

   bls_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .x_limit     (x_limit),
      .y_limit     (y_limit)
   );

   bls_req_reg #(.COORD_BITS(COORD_BITS)) u_req_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_color   (req_color),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_opcode   (in_opcode),
      .in_x_start  (in_x_start),
      .in_y_start  (in_y_start),
      .in_x_end    (in_x_end),
      .in_y_end    (in_y_end),
      .in_color    (in_color)
   );

   bls_line_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (in_valid),
      .in_opcode       (in_opcode),
      .in_x_start      (in_x_start),
      .in_y_start      (in_y_start),
      .in_x_end        (in_x_end),
      .in_y_end        (in_y_end),
      .in_color        (in_color),
      .advance         (advance),
      .x_limit         (x_limit),
      .y_limit         (y_limit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_visible     (rsp_visible),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int CB          = bls_pkg::COORD_BITS;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 4;
   localparam int PHASE_ITEMS = 80;

   typedef logic [bls_pkg::CSR_DATA_BITS-1:0] csr_word_type;

   typedef struct packed {
      logic                           valid_res;
      logic [CB-1:0]                  x;
      logic [CB-1:0]                  y;
      logic [bls_pkg::COLOR_BITS-1:0] color;
      logic                           visible;
      logic                           last;
   } pixel_type;

   typedef struct packed {
      bls_pkg::bls_opcode_type        op;
      logic [CB-1:0]                  xs;
      logic [CB-1:0]                  ys;
      logic [CB-1:0]                  xe;
      logic [CB-1:0]                  ye;
      logic [bls_pkg::COLOR_BITS-1:0] col;
      logic                           typed;
      pixel_type                      want;
   } line_row_type;

   localparam pixel_type IDLE_PIX = '0;

   // typed rows carry their own expected pixel, the rest go through the predictor
   localparam line_row_type DIRECTED_ROWS [25] = '{
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b1, IDLE_PIX},
      '{bls_pkg::OP_LOAD, 12'd5, 12'd7, 12'd5, 12'd7, 16'hFFFF, 1'b1,
        '{1'b1, 12'd5, 12'd7, 16'hFFFF, 1'b1, 1'b1}},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b1, IDLE_PIX},
      '{bls_pkg::OP_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'h0000, 1'b1,
        '{1'b1, 12'd4095, 12'd4095, 16'h0000, 1'b0, 1'b1}},
      '{bls_pkg::OP_LOAD, 12'd239, 12'd399, 12'd239, 12'd399, 16'h1234, 1'b1,
        '{1'b1, 12'd239, 12'd399, 16'h1234, 1'b1, 1'b1}},
      '{bls_pkg::OP_LOAD, 12'd240, 12'd399, 12'd240, 12'd399, 16'h07E0, 1'b1,
        '{1'b1, 12'd240, 12'd399, 16'h07E0, 1'b0, 1'b1}},
      '{bls_pkg::OP_LOAD, 12'd239, 12'd400, 12'd239, 12'd400, 16'h001F, 1'b1,
        '{1'b1, 12'd239, 12'd400, 16'h001F, 1'b0, 1'b1}},
      // x major, both directions positive
      '{bls_pkg::OP_LOAD, 12'd0, 12'd0, 12'd4, 12'd2, 16'hF800, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 16'hAAAA, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 16'h5555, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b1, IDLE_PIX},
      // equal deltas, y wins the tie
      '{bls_pkg::OP_LOAD, 12'd10, 12'd10, 12'd7, 12'd13, 16'h8410, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      // long line, abandoned by the next load
      '{bls_pkg::OP_LOAD, 12'd4095, 12'd0, 12'd4093, 12'd4095, 16'h7BEF, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_LOAD, 12'd0, 12'd4095, 12'd0, 12'd4092, 16'h0001, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b0, IDLE_PIX},
      '{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b1, IDLE_PIX}
   };

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_opcode;
   logic [CB-1:0]                     req_x_start;
   logic [CB-1:0]                     req_y_start;
   logic [CB-1:0]                     req_x_end;
   logic [CB-1:0]                     req_y_end;
   logic [bls_pkg::COLOR_BITS-1:0]    req_color;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_valid_res;
   logic [CB-1:0]                     rsp_pixel_x;
   logic [CB-1:0]                     rsp_pixel_y;
   logic [bls_pkg::COLOR_BITS-1:0]    rsp_pixel_color;
   logic                              rsp_visible;
   logic                              rsp_last;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [bls_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   csr_word_type                      csr_pwdata;
   csr_word_type                      csr_prdata;
   logic                              csr_pready;

   bresenham_line_stepper i_dut (.*);

   // predictor state
   logic [CB-1:0]                  lim_x, lim_y;
   logic [CB-1:0]                  pos_x, pos_y;
   logic [CB-1:0]                  dist_x, dist_y;
   logic [CB-1:0]                  remaining;
   logic [bls_pkg::COLOR_BITS-1:0] line_col;
   logic                           neg_x, neg_y, x_is_major, in_line;
   int                             err;

   pixel_type pending_pixels[$];
   pixel_type seen_pixel;
   int        items_sent  = 0;
   int        fail_count  = 0;
   int        quiet_cycles = 0;
   int        idle_pct    = 25;
   int        stall_pct   = 25;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic pixel_type predict_pixel(line_row_type cmd);
      pixel_type     px;
      logic [CB-1:0] major;
      if (cmd.op == bls_pkg::OP_STEP && !in_line) return IDLE_PIX;
      if (cmd.op == bls_pkg::OP_LOAD) begin
         line_col   = cmd.col;
         dist_x     = (cmd.xe > cmd.xs) ? cmd.xe - cmd.xs : cmd.xs - cmd.xe;
         dist_y     = (cmd.ye > cmd.ys) ? cmd.ye - cmd.ys : cmd.ys - cmd.ye;
         neg_x      = !(cmd.xe > cmd.xs);
         neg_y      = !(cmd.ye > cmd.ys);
         x_is_major = dist_x > dist_y;
         major      = x_is_major ? dist_x : dist_y;
         err        = -int'(major);
         pos_x      = cmd.xs;
         pos_y      = cmd.ys;
         remaining  = major;
      end else begin
         remaining = remaining - 1'b1;
      end
      px.valid_res = 1'b1;
      px.x         = pos_x;
      px.y         = pos_y;
      px.color     = line_col;
      px.visible   = (pos_x <= lim_x) && (pos_y <= lim_y);
      px.last      = (remaining == '0);
      in_line      = !px.last;
      // move on to the next pixel of the line
      if (x_is_major) begin
         pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
         err   = err + 2 * int'(dist_y);
         if (err >= 0) begin
            pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
            err   = err - 2 * int'(dist_x);
         end
      end else begin
         pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
         err   = err + 2 * int'(dist_x);
         if (err >= 0) begin
            pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            err   = err - 2 * int'(dist_y);
         end
      end
      return px;
   endfunction

   task automatic send_line_cmd(input line_row_type cmd);
      pixel_type guess;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= cmd.op;
      req_x_start <= cmd.xs;
      req_y_start <= cmd.ys;
      req_x_end   <= cmd.xe;
      req_y_end   <= cmd.ye;
      req_color   <= cmd.col;
      do @(posedge clock); while (req_stall);
      guess = predict_pixel(cmd);
      pending_pixels.push_back(cmd.typed ? cmd.want : guess);
      items_sent++;
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(input bls_pkg::bls_reg_type idx, input logic [CB-1:0] val);
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= csr_word_type'(val);
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == bls_pkg::REG_X_LIMIT) lim_x = val;
      else lim_y = val;
      // read back through the same port
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== csr_word_type'(val)) begin
         $error("prdata: expected %0d, got %0d", val, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random_lines(input int upto);
      line_row_type cmd;
      int           start_c[2], stop_c[2];
      int           span, steps, gap, n;
      while (items_sent < upto) begin
         span = 0;
         for (int k = 0; k < 2; k++) begin
            start_c[k] = ($urandom_range(1) == 1) ? $urandom_range(4095) : $urandom_range(511);
            if ($urandom_range(9) == 0) begin
               stop_c[k] = $urandom_range(4095);
            end else begin
               stop_c[k] = start_c[k] + int'($urandom_range(24)) - 12;
               if (stop_c[k] < 0) stop_c[k] = 0;
               if (stop_c[k] > 4095) stop_c[k] = 4095;
            end
            gap = (stop_c[k] > start_c[k]) ? stop_c[k] - start_c[k] : start_c[k] - stop_c[k];
            if (gap > span) span = gap;
         end
         cmd       = '0;
         cmd.op    = bls_pkg::OP_LOAD;
         cmd.xs    = CB'(start_c[0]);
         cmd.ys    = CB'(start_c[1]);
         cmd.xe    = CB'(stop_c[0]);
         cmd.ye    = CB'(stop_c[1]);
         cmd.col   = bls_pkg::COLOR_BITS'($urandom_range(65535));
         n = $urandom_range(99);
         // mostly whole lines, some cut short by a new load, some overrun while idle
         if (n < 70) steps = span;
         else if (n < 85) steps = $urandom_range(span);
         else steps = span + $urandom_range(3, 1);
         if (steps > 40) steps = $urandom_range(40);
         send_line_cmd(cmd);
         for (n = 0; n < steps; n++) begin
            cmd     = '0;
            cmd.op  = bls_pkg::OP_STEP;
            cmd.xs  = CB'($urandom_range(4095));
            cmd.ys  = CB'($urandom_range(4095));
            cmd.xe  = CB'($urandom_range(4095));
            cmd.ye  = CB'($urandom_range(4095));
            cmd.col = bls_pkg::COLOR_BITS'($urandom_range(65535));
            send_line_cmd(cmd);
         end
      end
   endtask

   task automatic compare_pixel(input pixel_type got, input pixel_type want);
      if (got.valid_res !== want.valid_res) begin
         $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
         fail_count++;
      end
      if (got.x !== want.x) begin
         $error("pixel_x: expected %0d, got %0d", want.x, got.x);
         fail_count++;
      end
      if (got.y !== want.y) begin
         $error("pixel_y: expected %0d, got %0d", want.y, got.y);
         fail_count++;
      end
      if (got.color !== want.color) begin
         $error("pixel_color: expected %0h, got %0h", want.color, got.color);
         fail_count++;
      end
      if (got.visible !== want.visible) begin
         $error("visible: expected %0d, got %0d", want.visible, got.visible);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         fail_count++;
      end
   endtask

   // result side: random stall, compare every accepted transaction
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         seen_pixel = '{rsp_valid_res, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                        rsp_visible, rsp_last};
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
            fail_count++;
         end else begin
            compare_pixel(seen_pixel, pending_pixels.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_opcode  <= bls_pkg::OP_LOAD;
      req_x_start <= '0;
      req_y_start <= '0;
      req_x_end   <= '0;
      req_y_end   <= '0;
      req_color   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      lim_x      = CB'(bls_pkg::X_LIMIT_RESET);
      lim_y      = CB'(bls_pkg::Y_LIMIT_RESET);
      pos_x      = '0;
      pos_y      = '0;
      dist_x     = '0;
      dist_y     = '0;
      remaining  = '0;
      line_col   = '0;
      neg_x      = 1'b0;
      neg_y      = 1'b0;
      x_is_major = 1'b0;
      in_line    = 1'b0;
      err        = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) send_line_cmd(DIRECTED_ROWS[i]);
      drain_pixels();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_limit(bls_pkg::REG_X_LIMIT, 12'd4095);
               write_limit(bls_pkg::REG_Y_LIMIT, 12'd4095);
            end
            1: begin
               write_limit(bls_pkg::REG_X_LIMIT, 12'd0);
               write_limit(bls_pkg::REG_Y_LIMIT, 12'd0);
            end
            2: begin
               write_limit(bls_pkg::REG_X_LIMIT, CB'($urandom_range(600)));
               write_limit(bls_pkg::REG_Y_LIMIT, CB'($urandom_range(600)));
            end
            3: begin
               write_limit(bls_pkg::REG_X_LIMIT, 12'd239);
               write_limit(bls_pkg::REG_Y_LIMIT, 12'd399);
            end
            default: begin
               write_limit(bls_pkg::REG_X_LIMIT, CB'($urandom_range(4095)));
               write_limit(bls_pkg::REG_Y_LIMIT, CB'($urandom_range(4095)));
            end
         endcase
         // one phase runs back to back on both sides
         idle_pct  = (phase == 2) ? 0 : 25;
         stall_pct = (phase == 2) ? 0 : 25;
         run_random_lines(items_sent + PHASE_ITEMS);
         drain_pixels();
      end

      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== bresenham_line_stepper.f =====
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_csr.sv
rtl/bls_req_reg.sv
rtl/bls_line_core.sv
rtl/bresenham_line_stepper.sv
verif/testbench.sv
